@@ src/tdt_pkg.sv @@
// ----------------------------------------------------------------------------
// tdt_pkg
// Types, widths and codes shared by the timeout deadline table.
// ----------------------------------------------------------------------------
package tdt_pkg;

  localparam int ACT_W      = 2;
  localparam int DELAY_W    = 31;
  localparam int ID_W       = 31;
  localparam int STATUS_W   = 3;
  localparam int TIME_W     = 48;
  localparam int MAX_ENTRIES_DEF = 64;

  localparam logic [ID_W-1:0] ID_MAX   = {ID_W{1'b1}};
  localparam logic [ID_W-1:0] ID_FIRST = ID_W'(1);
  localparam logic [ID_W-1:0] ID_NONE  = '0;

  localparam logic [ACT_W-1:0] ACT_ADD    = 2'd0;
  localparam logic [ACT_W-1:0] ACT_CANCEL = 2'd1;
  localparam logic [ACT_W-1:0] ACT_TICK   = 2'd2;
  localparam logic [ACT_W-1:0] ACT_NOP    = 2'd3;

  localparam logic [STATUS_W-1:0] STAT_ADDED     = 3'd0;
  localparam logic [STATUS_W-1:0] STAT_FULL      = 3'd1;
  localparam logic [STATUS_W-1:0] STAT_CANCELLED = 3'd2;
  localparam logic [STATUS_W-1:0] STAT_NOTFOUND  = 3'd3;
  localparam logic [STATUS_W-1:0] STAT_EXPIRED   = 3'd4;

  typedef struct packed {
    logic [TIME_W-1:0] deadline;
    logic [ID_W-1:0]   id;
  } entry_t;

endpackage

@@ src/tdt_req_if.sv @@
// ----------------------------------------------------------------------------
// tdt_req_if
// Request channel: add, cancel or tick word with valid/ready handshake.
// ----------------------------------------------------------------------------
interface tdt_req_if;
  logic                        valid;
  logic                        ready;
  logic [tdt_pkg::ACT_W-1:0]   action;
  logic [tdt_pkg::DELAY_W-1:0] delay_ms;
  logic [tdt_pkg::ID_W-1:0]    cancel_id;

  modport source (output valid, action, delay_ms, cancel_id, input ready);
  modport sink   (input valid, action, delay_ms, cancel_id, output ready);
endinterface

@@ src/tdt_rsp_if.sv @@
// ----------------------------------------------------------------------------
// tdt_rsp_if
// Result channel: status, id and last marker with valid/ready handshake.
// ----------------------------------------------------------------------------
interface tdt_rsp_if;
  logic                         valid;
  logic                         ready;
  logic [tdt_pkg::STATUS_W-1:0] status;
  logic [tdt_pkg::ID_W-1:0]     task_id;
  logic                         last;

  modport source (output valid, status, task_id, last, input ready);
  modport sink   (input valid, status, task_id, last, output ready);
endinterface

@@ src/timeout_deadline_table.sv @@
// ----------------------------------------------------------------------------
// timeout_deadline_table
// Table of pending millisecond timeouts held in one synchronous entry store.
// ----------------------------------------------------------------------------
// Add: S_FIN loads the result word into the result register, then the next word is taken.
// Cancel and tick: a read-then-write pass in which each of the N stored entries takes a read
//   (S_RD) and a compact step (S_EV); S_FIN then gives the last result word.
// The pass stalls only while the result register is held by the sink.
// Reset clears count, clock (0) and next id (1); store contents stay undefined
//   and are never read before written, so there is no clearing pass.
module timeout_deadline_table #(
  parameter int MAX_ENTRIES = tdt_pkg::MAX_ENTRIES_DEF
) (
  input logic       clk,
  input logic       rst,
  tdt_req_if.sink   req,
  tdt_rsp_if.source rsp
);

  localparam int AW    = $clog2(MAX_ENTRIES);
  localparam int CNT_W = $clog2(MAX_ENTRIES + 1);
  localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_ENTRIES);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_RD   = 2'd1;
  localparam logic [1:0] S_EV   = 2'd2;
  localparam logic [1:0] S_FIN  = 2'd3;

  tdt_pkg::entry_t mem [MAX_ENTRIES];
  tdt_pkg::entry_t rd_q;

  logic [1:0]                    state;
  logic [tdt_pkg::ACT_W-1:0]     op;
  logic [CNT_W-1:0]              count;
  logic [CNT_W-1:0]              rptr;
  logic [CNT_W-1:0]              wptr;
  logic [tdt_pkg::ID_W-1:0]      next_id;
  logic [tdt_pkg::TIME_W-1:0]    now_ms;
  logic [tdt_pkg::ID_W-1:0]      op_id;
  logic                          op_full;
  logic                          found;
  logic                          pend_valid;
  logic [tdt_pkg::ID_W-1:0]      pend_id;

  logic                          out_valid;
  logic [tdt_pkg::STATUS_W-1:0]  out_status;
  logic [tdt_pkg::ID_W-1:0]      out_id;
  logic                          out_last;

  logic                          accept;
  logic                          out_free;
  logic                          push;
  logic [tdt_pkg::STATUS_W-1:0]  push_status;
  logic [tdt_pkg::ID_W-1:0]      push_id;
  logic                          push_last;
  logic                          hit;
  logic                          ev_stall;
  logic                          wr_en;
  logic [AW-1:0]                 wr_addr;
  tdt_pkg::entry_t               wr_data;
  logic                          rd_en;
  logic                          add_ok;

  assign req.ready   = (state == S_IDLE);
  assign accept      = req.valid && req.ready;
  assign out_free    = !out_valid || rsp.ready;
  assign add_ok      = (count < CNT_MAX);

  assign rsp.valid   = out_valid;
  assign rsp.status  = out_status;
  assign rsp.task_id = out_id;
  assign rsp.last    = out_last;

  // entry under inspection leaves the table?
  always_comb begin
    hit = 1'b0;
    if (op == tdt_pkg::ACT_TICK) begin
      hit = (rd_q.deadline <= now_ms);
    end else begin
      hit = !found && (op_id != tdt_pkg::ID_NONE) && (rd_q.id == op_id);
    end
  end

  // an expired entry can only replace the pending one once that is passed on
  assign ev_stall = (state == S_EV) && hit && (op == tdt_pkg::ACT_TICK) &&
                    pend_valid && !out_free;

  assign rd_en = (state == S_RD) && (rptr != count);

  always_comb begin
    push        = 1'b0;
    push_status = tdt_pkg::STAT_EXPIRED;
    push_id     = pend_id;
    push_last   = 1'b0;
    if (state == S_EV) begin
      push = hit && (op == tdt_pkg::ACT_TICK) && pend_valid && out_free;
    end else if (state == S_FIN) begin
      push_last = 1'b1;
      case (op)
        tdt_pkg::ACT_ADD: begin
          push        = out_free;
          push_status = op_full ? tdt_pkg::STAT_FULL : tdt_pkg::STAT_ADDED;
          push_id     = op_id;
        end
        tdt_pkg::ACT_CANCEL: begin
          push        = out_free;
          push_status = found ? tdt_pkg::STAT_CANCELLED : tdt_pkg::STAT_NOTFOUND;
          push_id     = found ? op_id : tdt_pkg::ID_NONE;
        end
        default: begin
          push = pend_valid && out_free;
        end
      endcase
    end
  end

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = wptr[AW-1:0];
    wr_data = rd_q;
    if (accept && (req.action == tdt_pkg::ACT_ADD) && add_ok) begin
      wr_en            = 1'b1;
      wr_addr          = count[AW-1:0];
      wr_data.deadline = now_ms + tdt_pkg::TIME_W'(req.delay_ms);
      wr_data.id       = next_id;
    end else if ((state == S_EV) && !hit) begin
      // keep: move down over the gap left by removed entries
      wr_en = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_q <= mem[rptr[AW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      op         <= tdt_pkg::ACT_NOP;
      count      <= '0;
      rptr       <= '0;
      wptr       <= '0;
      next_id    <= tdt_pkg::ID_FIRST;
      now_ms     <= '0;
      op_id      <= tdt_pkg::ID_NONE;
      op_full    <= 1'b0;
      found      <= 1'b0;
      pend_valid <= 1'b0;
      pend_id    <= tdt_pkg::ID_NONE;
      out_valid  <= 1'b0;
      out_status <= tdt_pkg::STAT_ADDED;
      out_id     <= tdt_pkg::ID_NONE;
      out_last   <= 1'b0;
    end else begin
      if (push) begin
        out_valid  <= 1'b1;
        out_status <= push_status;
        out_id     <= push_id;
        out_last   <= push_last;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end

      unique case (state)
        S_IDLE: begin
          if (accept) begin
            op         <= req.action;
            rptr       <= '0;
            wptr       <= '0;
            found      <= 1'b0;
            pend_valid <= 1'b0;
            unique case (req.action)
              tdt_pkg::ACT_ADD: begin
                state   <= S_FIN;
                op_full <= !add_ok;
                if (add_ok) begin
                  op_id   <= next_id;
                  count   <= count + CNT_W'(1);
                  next_id <= (next_id == tdt_pkg::ID_MAX) ? tdt_pkg::ID_FIRST
                                                          : next_id + tdt_pkg::ID_W'(1);
                end else begin
                  op_id <= tdt_pkg::ID_NONE;
                end
              end
              tdt_pkg::ACT_CANCEL: begin
                state <= S_RD;
                op_id <= req.cancel_id;
              end
              tdt_pkg::ACT_TICK: begin
                state  <= S_RD;
                now_ms <= now_ms + tdt_pkg::TIME_W'(1);
              end
              default: begin
                state <= S_IDLE;
              end
            endcase
          end
        end
        S_RD: begin
          if (rptr == count) begin
            count <= wptr;
            state <= S_FIN;
          end else begin
            state <= S_EV;
          end
        end
        S_EV: begin
          if (!ev_stall) begin
            if (hit) begin
              if (op == tdt_pkg::ACT_TICK) begin
                pend_valid <= 1'b1;
                pend_id    <= rd_q.id;
              end else begin
                found <= 1'b1;
              end
            end else begin
              wptr <= wptr + CNT_W'(1);
            end
            rptr  <= rptr + CNT_W'(1);
            state <= S_RD;
          end
        end
        S_FIN: begin
          if (push || ((op == tdt_pkg::ACT_TICK) && !pend_valid)) begin
            pend_valid <= 1'b0;
            state      <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

@@ sim/tdt_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tdt_checker
// Watches the request and result channels of the timeout deadline table,
// keeps its own copy of the timer table and clock, works out the result
// words that each accepted request must cause, and compares every accepted
// result word with the oldest one still owed.
// ----------------------------------------------------------------------------
module tdt_checker #(
  parameter int MAX_ENTRIES = tdt_pkg::MAX_ENTRIES_DEF
) (
  input  logic clk,
  input  logic rst,
  tdt_req_if   req,
  tdt_rsp_if   rsp,
  output int   fail_count,
  output int   pending
);
  import tdt_pkg::*;

  localparam int REPORT_LIMIT = 10;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [ID_W-1:0]     task_id;
    logic                last;
  } tdt_result_t;

  entry_t            timers[$];
  tdt_result_t       owed_results[$];
  logic [ID_W-1:0]   next_timer_id = ID_FIRST;
  logic [TIME_W-1:0] clock_ms = '0;

  function automatic void owe(input logic [STATUS_W-1:0] st, input logic [ID_W-1:0] id);
    tdt_result_t r;
    r.status  = st;
    r.task_id = id;
    r.last    = 1'b0;
    owed_results.push_back(r);
  endfunction

  task automatic apply_timer_request(input logic [ACT_W-1:0]   act,
                                     input logic [DELAY_W-1:0] dly,
                                     input logic [ID_W-1:0]    cid);
    int          owed_start;
    int          i;
    entry_t      e;
    tdt_result_t tail;
    owed_start = owed_results.size();
    case (act)
      ACT_ADD: begin
        if (timers.size() >= MAX_ENTRIES) begin
          owe(STAT_FULL, ID_NONE);
        end else begin
          e.deadline = clock_ms + TIME_W'(dly);
          e.id       = next_timer_id;
          timers.push_back(e);
          owe(STAT_ADDED, next_timer_id);
          next_timer_id = (next_timer_id == ID_MAX) ? ID_FIRST : next_timer_id + ID_W'(1);
        end
      end
      ACT_CANCEL: begin
        i = 0;
        while (i < timers.size() && timers[i].id != cid) i++;
        // first match only; the rest keep their order
        if (cid != ID_NONE && i < timers.size()) begin
          timers.delete(i);
          owe(STAT_CANCELLED, cid);
        end else begin
          owe(STAT_NOTFOUND, ID_NONE);
        end
      end
      ACT_TICK: begin
        clock_ms = clock_ms + TIME_W'(1);
        i = 0;
        while (i < timers.size()) begin
          if (timers[i].deadline <= clock_ms) begin
            owe(STAT_EXPIRED, timers[i].id);
            timers.delete(i);
          end else begin
            i++;
          end
        end
      end
      default: begin
        // spare action code: dropped without a word
      end
    endcase
    if (owed_results.size() > owed_start) begin
      tail      = owed_results.pop_back();
      tail.last = 1'b1;
      owed_results.push_back(tail);
    end
  endtask

  always @(posedge clk) begin : watch
    tdt_result_t want;
    if (rst) begin
      timers.delete();
      owed_results.delete();
      next_timer_id = ID_FIRST;
      clock_ms      = '0;
      fail_count    = 0;
    end else begin
      // results first: a request accepted on this edge cannot have caused one yet
      if (rsp.valid && rsp.ready) begin
        if (owed_results.size() == 0) begin
          fail_count++;
          if (fail_count <= REPORT_LIMIT)
            $display("[%0t] unexpected result word: status %0d id %0d last %0b",
                     $time, rsp.status, rsp.task_id, rsp.last);
        end else begin
          want = owed_results.pop_front();
          if (rsp.status !== want.status || rsp.task_id !== want.task_id ||
              rsp.last !== want.last) begin
            fail_count++;
            if (fail_count <= REPORT_LIMIT)
              $display("[%0t] result word wrong: expected status %0d id %0d last %0b,%s",
                       $time, want.status, want.task_id, want.last,
                       $sformatf(" got status %0d id %0d last %0b",
                                 rsp.status, rsp.task_id, rsp.last));
          end
        end
      end
      if (req.valid && req.ready)
        apply_timer_request(req.action, req.delay_ms, req.cancel_id);
    end
    pending = owed_results.size();
  end

endmodule

@@ sim/tb_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Drives add, cancel and tick words into the timeout deadline table in
// random bursts while the result side stalls on a pattern of its own; a
// directed opening covers the corner cases, then random timer traffic with
// table floods follows. The checker beside the block judges every result.
// ----------------------------------------------------------------------------
module tb_top;
  import tdt_pkg::*;

  localparam int     TABLE_DEPTH   = MAX_ENTRIES_DEF;
  localparam int     RANDOM_WORDS  = 460;
  localparam int     SETTLE_CYCLES = 2 * TABLE_DEPTH + 40;
  localparam longint TIMEOUT_NS    = 64'd50_000_000;

  typedef enum {RX_OPEN, RX_MOSTLY, RX_SPARSE, RX_LONG} rx_mode_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  int   fail_count;
  int   pending;

  int              burst_left = 1;
  int              words_sent = 0;
  int              ids_issued = 0;
  logic [ID_W-1:0] parked_ids[$];

  tdt_req_if req_ch ();
  tdt_rsp_if rsp_ch ();

  timeout_deadline_table #(.MAX_ENTRIES(TABLE_DEPTH)) dut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  tdt_checker #(.MAX_ENTRIES(TABLE_DEPTH)) u_checker (
    .clk        (clk),
    .rst        (rst),
    .req        (req_ch),
    .rsp        (rsp_ch),
    .fail_count (fail_count),
    .pending    (pending)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    #(TIMEOUT_NS);
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // result side: ready pattern switches between random modes
  initial begin : rsp_stalls
    rx_mode_t mode;
    int       hold;
    rsp_ch.ready = 1'b0;
    hold = 0;
    forever begin
      mode = rx_mode_t'($urandom_range(0, 3));
      repeat ($urandom_range(40, 160)) begin
        @(negedge clk);
        case (mode)
          RX_OPEN:   rsp_ch.ready <= 1'b1;
          RX_MOSTLY: rsp_ch.ready <= ($urandom_range(0, 3) != 0);
          RX_SPARSE: rsp_ch.ready <= ($urandom_range(0, 3) == 0);
          default: begin
            // long stalls, short openings
            if (hold == 0) begin
              hold = rsp_ch.ready ? $urandom_range(1, 20) : $urandom_range(1, 4);
              rsp_ch.ready <= !rsp_ch.ready;
            end else begin
              hold--;
            end
          end
        endcase
      end
    end
  end

  task automatic offer_word(input logic [ACT_W-1:0]   act,
                            input logic [DELAY_W-1:0] dly,
                            input logic [ID_W-1:0]    cid);
    req_ch.valid     <= 1'b1;
    req_ch.action    <= act;
    req_ch.delay_ms  <= dly;
    req_ch.cancel_id <= cid;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    @(negedge clk);
    if (act != ACT_NOP) words_sent++;
    burst_left--;
    if (burst_left <= 0) begin
      req_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(negedge clk);
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(30, 60) : $urandom_range(1, 8);
    end
  endtask

  task automatic send_tick();
    offer_word(ACT_TICK, DELAY_W'($urandom()), ID_W'($urandom()));
  endtask

  // ids run from 1 in add order while the table has room
  task automatic add_timer(input logic [DELAY_W-1:0] dly, input bit park);
    ids_issued++;
    if (park) parked_ids.push_back(ID_W'(ids_issued));
    offer_word(ACT_ADD, dly, ID_W'($urandom()));
  endtask

  task automatic wait_quiet();
    req_ch.valid <= 1'b0;
    @(negedge clk);
    wait (pending == 0);
    @(negedge clk);
    burst_left = $urandom_range(1, 8);
  endtask

  // overfill the table with near deadlines, then tick them all out
  task automatic flood_table(input int spread);
    repeat (TABLE_DEPTH + $urandom_range(2, 6))
      add_timer(DELAY_W'($urandom_range(0, spread)), 1'b0);
    repeat (spread + 1) send_tick();
    wait_quiet();
  endtask

  initial begin : stimulus
    int              start_words;
    int              pick;
    int              span;
    bit              second_flood;
    logic [ID_W-1:0] cid;
    req_ch.valid     = 1'b0;
    req_ch.action    = ACT_NOP;
    req_ch.delay_ms  = '0;
    req_ch.cancel_id = '0;
    second_flood     = 1'b0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    offer_word(ACT_NOP, '1, '1);
    send_tick();
    offer_word(ACT_CANCEL, '0, ID_NONE);
    offer_word(ACT_CANCEL, '1, ID_MAX);
    add_timer('0, 1'b0);                       // id 1, due on the next tick
    send_tick();
    add_timer('1, 1'b0);                       // id 2, never due
    add_timer(DELAY_W'(1), 1'b0);              // id 3
    add_timer(DELAY_W'(2), 1'b0);              // id 4
    add_timer(DELAY_W'(1), 1'b0);              // id 5
    add_timer('0, 1'b0);                       // id 6
    offer_word(ACT_CANCEL, '0, ID_W'(4));      // drop from the middle
    offer_word(ACT_CANCEL, '0, ID_W'(4));
    send_tick();                               // 3, 5, 6 in table order
    send_tick();
    add_timer(DELAY_W'(31'h5555_5555), 1'b0);  // id 7
    add_timer(DELAY_W'(31'h2AAA_AAAA), 1'b0);  // id 8
    offer_word(ACT_CANCEL, '0, ID_W'(2));      // head
    offer_word(ACT_CANCEL, '0, ID_W'(8));      // tail
    offer_word(ACT_CANCEL, '0, ID_W'(7));
    offer_word(ACT_CANCEL, '1, ID_W'(31'h5555_5555));
    offer_word(ACT_CANCEL, '0, ID_W'(31'h2AAA_AAAA));
    offer_word(ACT_NOP, DELAY_W'($urandom()), ID_W'($urandom()));
    wait_quiet();

    start_words = words_sent;
    flood_table(0);
    while (words_sent < start_words + RANDOM_WORDS) begin
      pick = $urandom_range(0, 99);
      if (!second_flood && words_sent >= start_words + RANDOM_WORDS / 2) begin
        second_flood = 1'b1;
        flood_table(3);
      end else if (pick < 30) begin
        send_tick();
      end else if (pick < 52) begin
        add_timer(DELAY_W'($urandom_range(0, 20)), 1'b0);
      end else if (pick < 62) begin
        add_timer(DELAY_W'($urandom_range(21, 60)), 1'b0);
      end else if (pick < 68) begin
        add_timer(DELAY_W'($urandom()), 1'b1);
      end else if (pick < 80) begin
        span = $urandom_range(0, 24);
        cid  = (ids_issued > span) ? ID_W'(ids_issued - span) : ID_NONE;
        offer_word(ACT_CANCEL, DELAY_W'($urandom()), cid);
      end else if (pick < 87) begin
        if (parked_ids.size() > 0) begin
          span = $urandom_range(0, parked_ids.size() - 1);
          cid  = parked_ids[span];
          parked_ids.delete(span);
        end else begin
          cid = ID_W'($urandom());
        end
        offer_word(ACT_CANCEL, DELAY_W'($urandom()), cid);
      end else if (pick < 93) begin
        offer_word(ACT_CANCEL, DELAY_W'($urandom()), ID_W'($urandom()));
      end else if (pick < 96) begin
        offer_word(ACT_CANCEL, DELAY_W'($urandom()), pick[0] ? ID_MAX : ID_NONE);
      end else begin
        offer_word(ACT_NOP, DELAY_W'($urandom()), ID_W'($urandom()));
      end
      if ($urandom_range(0, 59) == 0) wait_quiet();
    end

    req_ch.valid <= 1'b0;
    wait (pending == 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
